// File: hdl/krt_pkg.sv
package krt_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  localparam int WORD_W = 32;
  localparam int POS_W = 4;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_EDIT   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] key;
    logic signed [WORD_W-1:0] code;
    logic signed [WORD_W-1:0] power;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

// File: hdl/keyed_record_table.sv
// Ordered table of up to ENTRIES device records (serial key, device code, power), kept in
// append order in one record RAM. Each command is one transfer in and gives one result
// transfer out. Look up, edit and remove scan the records from the head through the single
// read port of the RAM, one record per cycle, until a match or the last stored record. A
// removal then moves every later record down one place through the same port, one per
// cycle. The input is stalled while a command is in progress; a finished result waits in
// an output register, and the next command is accepted meanwhile.
module keyed_record_table #(
  parameter int ENTRIES = krt_pkg::ENTRIES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         command,
  input  logic signed [krt_pkg::WORD_W-1:0]  serial_key,
  input  logic signed [krt_pkg::WORD_W-1:0]  device_code,
  input  logic signed [krt_pkg::WORD_W-1:0]  power_value,
  input  logic signed [krt_pkg::WORD_W-1:0]  replacement_key,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic [krt_pkg::POS_W-1:0]          position,
  output logic signed [krt_pkg::WORD_W-1:0]  found_code,
  output logic signed [krt_pkg::WORD_W-1:0]  found_key,
  output logic signed [krt_pkg::WORD_W-1:0]  found_power
);

  import krt_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] idx, idx_next;
  cmd_t cmd;
  logic signed [WORD_W-1:0] want_key;
  logic signed [WORD_W-1:0] new_key;
  status_t res_status, res_status_next;
  logic [POS_W-1:0] res_pos, res_pos_next;
  rec_t res_rec, res_rec_next;

  logic we;
  logic [AW-1:0] waddr, raddr;
  rec_t wdata, rdata;
  logic [REC_W-1:0] rdata_raw;

  logic accept, out_load;
  logic [CW-1:0] idx_ext, idx_p1, idx_p2;
  logic [AW+POS_W-1:0] idx_pos_ext;
  logic [CW+POS_W-1:0] cnt_pos_ext;

  krt_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  assign rdata = rec_t'(rdata_raw);
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_load = (state == S_EMIT) && (!out_valid || !out_stall);
  assign idx_ext = CW'(idx);
  assign idx_p1 = idx_ext + CW'(1);
  assign idx_p2 = idx_ext + CW'(2);
  assign idx_pos_ext = {{POS_W{1'b0}}, idx};
  assign cnt_pos_ext = {{POS_W{1'b0}}, count};

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next = idx;
    res_status_next = res_status;
    res_pos_next = res_pos;
    res_rec_next = res_rec;
    we = 1'b0;
    waddr = idx;
    wdata = rdata;
    raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next = '0;
          state_next = S_EMIT;
          res_pos_next = '0;
          res_rec_next = '0;
          if (cmd_t'(command) == CMD_APPEND) begin
            if (count >= FULL_COUNT) begin
              res_status_next = ST_FULL;
            end else begin
              we = 1'b1;
              waddr = count[AW-1:0];
              wdata = '{key: serial_key, code: device_code, power: power_value};
              res_status_next = ST_OK;
              res_pos_next = cnt_pos_ext[POS_W-1:0];
              res_rec_next = '{key: serial_key, code: device_code, power: power_value};
              count_next = count + CW'(1);
            end
          end else if (count == '0) begin
            res_status_next = ST_EMPTY;
          end else begin
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        raddr = idx_p1[AW-1:0];
        if (rdata.key == want_key) begin
          res_status_next = ST_OK;
          res_pos_next = idx_pos_ext[POS_W-1:0];
          res_rec_next = rdata;
          state_next = S_EMIT;
          if (cmd == CMD_EDIT) begin
            we = 1'b1;
            wdata = '{key: new_key, code: rdata.code, power: rdata.power};
          end else if (cmd == CMD_REMOVE) begin
            if (idx_p1 < count) begin
              state_next = S_SHIFT;
            end else begin
              count_next = count - CW'(1);
            end
          end
        end else if (idx_p1 == count) begin
          res_status_next = ST_NOT_FOUND;
          state_next = S_EMIT;
        end else begin
          idx_next = idx_p1[AW-1:0];
        end
      end
      S_SHIFT: begin
        raddr = idx_p2[AW-1:0];
        we = 1'b1;
        wdata = rdata;
        idx_next = idx_p1[AW-1:0];
        if (idx_p2 == count) begin
          count_next = count - CW'(1);
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    res_status <= res_status_next;
    res_pos <= res_pos_next;
    res_rec <= res_rec_next;
    if (accept) begin
      cmd <= cmd_t'(command);
      want_key <= serial_key;
      new_key <= replacement_key;
    end
    if (out_load) begin
      status <= res_status;
      position <= res_pos;
      found_code <= res_rec.code;
      found_key <= res_rec.key;
      found_power <= res_rec.power;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("record count exceeds table size");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (idx_p2 <= count))
    else $error("record move runs past the last record");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && out_stall) |=> (state == S_EMIT))
    else $error("pending result dropped while output is stalled");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd_t'(command) == CMD_APPEND && count < FULL_COUNT)
      |=> (count == $past(count) + CW'(1)))
    else $error("append did not grow the table");

  a_search_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (count != '0 && idx_ext < count))
    else $error("scan on an empty table or past its end");

endmodule

// File: hdl/krt_ram.sv
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: dv/tb_keyed_record_table.sv
`timescale 1ns / 1ps

module tb_keyed_record_table;
  import krt_pkg::*;

  localparam int DEPTH = ENTRIES_DEFAULT;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] key;
    logic [31:0] code;
    logic [31:0] power;
    logic [31:0] new_key;
  } table_cmd_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  pos;
    logic [31:0] code;
    logic [31:0] key;
    logic [31:0] power;
  } table_resp_t;

  typedef enum int {PH_FILL, PH_DRAIN} phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         command = CMD_APPEND;
  logic signed [31:0] serial_key = '0;
  logic signed [31:0] device_code = '0;
  logic signed [31:0] power_value = '0;
  logic signed [31:0] replacement_key = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [3:0]         position;
  logic signed [31:0] found_code;
  logic signed [31:0] found_key;
  logic signed [31:0] found_power;

  keyed_record_table #(.ENTRIES(DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .serial_key(serial_key),
    .device_code(device_code),
    .power_value(power_value),
    .replacement_key(replacement_key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .position(position),
    .found_code(found_code),
    .found_key(found_key),
    .found_power(found_power)
  );

  table_cmd_t  queued_commands[$];
  table_resp_t awaited_responses[$];

  logic [31:0] shadow_keys[DEPTH];
  logic [31:0] shadow_codes[DEPTH];
  logic [31:0] shadow_power[DEPTH];
  int          shadow_count = 0;
  int          peak_count = 0;
  int          status_seen[4] = '{0, 0, 0, 0};

  table_cmd_t  cur_cmd;
  int          gap_left = 0;
  int          stall_left = 0;
  int          sent_count = 0;
  int          result_count = 0;
  int          fail_count = 0;

  logic [31:0] key_pool[12];
  int          pool_n = 4;

  function automatic table_resp_t apply_to_shadow_table(table_cmd_t c);
    table_resp_t r;
    int hit_idx;
    int i;
    r = '{status: ST_OK, pos: 4'd0, code: '0, key: '0, power: '0};
    hit_idx = -1;
    if (c.cmd == CMD_APPEND) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        shadow_keys[shadow_count] = c.key;
        shadow_codes[shadow_count] = c.code;
        shadow_power[shadow_count] = c.power;
        r.pos = shadow_count[3:0];
        r.code = c.code;
        r.key = c.key;
        r.power = c.power;
        shadow_count++;
        if (shadow_count > peak_count) peak_count = shadow_count;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      for (i = 0; i < shadow_count; i++) begin
        if (hit_idx < 0 && shadow_keys[i] == c.key) hit_idx = i;
      end
      if (hit_idx < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.pos = hit_idx[3:0];
        r.code = shadow_codes[hit_idx];
        r.key = shadow_keys[hit_idx];
        r.power = shadow_power[hit_idx];
        if (c.cmd == CMD_EDIT) begin
          shadow_keys[hit_idx] = c.new_key;
        end else if (c.cmd == CMD_REMOVE) begin
          for (i = hit_idx; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_codes[i] = shadow_codes[i + 1];
            shadow_power[i] = shadow_power[i + 1];
          end
          shadow_count--;
        end
      end
    end
    status_seen[r.status]++;
    return r;
  endfunction

  task automatic queue_cmd(input cmd_t c, input logic [31:0] k, input logic [31:0] cd,
                           input logic [31:0] pw, input logic [31:0] nk);
    queued_commands.push_back('{cmd: c, key: k, code: cd, power: pw, new_key: nk});
  endtask

  task automatic check_field(input string label, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want_v, got_v);
      fail_count++;
    end
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, pool_n - 1)];
    return $urandom;
  endfunction

  task automatic wait_for_drain();
    while (!(queued_commands.size() == 0 && !in_valid && awaited_responses.size() == 0))
      @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Driver: one command transfer at a time, with a random gap after each one except in stretches sent back to back.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_responses.push_back(apply_to_shadow_table(cur_cmd));
        sent_count++;
        gap_left = (((sent_count / 150) % 4) == 3) ? 0 : $urandom_range(0, 10);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_commands.size() > 0) begin
          cur_cmd = queued_commands.pop_front();
          in_valid <= 1'b1;
          command <= cur_cmd.cmd;
          serial_key <= cur_cmd.key;
          device_code <= cur_cmd.code;
          power_value <= cur_cmd.power;
          replacement_key <= cur_cmd.new_key;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and draws the stall that follows it.
  always @(posedge clk) begin
    table_resp_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_responses.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d pos %0d",
                   $time, status, position);
          fail_count++;
        end else begin
          want = awaited_responses.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("position", 32'(want.pos), 32'(position));
          check_field("found_code", want.code, found_code);
          check_field("found_key", want.key, found_key);
          check_field("found_power", want.power, found_power);
        end
        result_count++;
        stall_left = (((result_count / 170) % 4) == 1) ? 0 : $urandom_range(0, 10);
        if (result_count == 600) stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #6000000;
    $display("Timeout after %0d commands and %0d results.", sent_count, result_count);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    phase_t ph_kind;
    int ph;
    int n;
    int r;
    int k;
    logic [31:0] kv;
    logic [31:0] cv;
    logic [31:0] pv;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    queue_cmd(CMD_LOOKUP, 32'h0000_0005, '0, '0, '0);
    queue_cmd(CMD_EDIT, 32'h8000_0000, '0, '0, 32'h7FFF_FFFF);
    queue_cmd(CMD_REMOVE, 32'hFFFF_FFFF, '0, '0, '0);
    for (k = 0; k < DEPTH; k++) begin
      case (k)
        0:       kv = 32'h8000_0000;
        1:       kv = 32'h0000_0000;
        2:       kv = 32'hFFFF_FFFF;
        15:      kv = 32'h7FFF_FFFF;
        default: kv = $urandom;
      endcase
      case (k % 4)
        0:       begin cv = 32'h8000_0000; pv = 32'h7FFF_FFFF; end
        1:       begin cv = 32'h7FFF_FFFF; pv = 32'h0000_0000; end
        2:       begin cv = 32'h0000_0000; pv = 32'h8000_0000; end
        default: begin cv = $urandom;      pv = $urandom;      end
      endcase
      queue_cmd(CMD_APPEND, kv, cv, pv, $urandom);
    end
    queue_cmd(CMD_APPEND, $urandom, $urandom, $urandom, $urandom);
    queue_cmd(CMD_LOOKUP, 32'h8000_0000, $urandom, $urandom, $urandom);
    queue_cmd(CMD_LOOKUP, 32'h7FFF_FFFF, $urandom, $urandom, $urandom);
    queue_cmd(CMD_LOOKUP, 32'h1234_5678, $urandom, $urandom, $urandom);
    queue_cmd(CMD_EDIT, 32'h0000_0000, $urandom, $urandom, 32'h5A5A_A5A5);
    queue_cmd(CMD_REMOVE, 32'h8000_0000, $urandom, $urandom, $urandom);
    queue_cmd(CMD_REMOVE, 32'h7FFF_FFFF, $urandom, $urandom, $urandom);
    queue_cmd(CMD_REMOVE, 32'hFFFF_FFFF, $urandom, $urandom, $urandom);
    wait_for_drain();

    // Alternate append-heavy and remove-heavy phases so the table swings between
    // empty and full, with keys drawn mostly from a small pool so searches hit.
    for (ph = 0; ph < 28; ph++) begin
      ph_kind = (ph % 2 == 0) ? PH_FILL : PH_DRAIN;
      if (ph_kind == PH_FILL) begin
        pool_n = $urandom_range(4, 12);
        for (k = 0; k < 12; k++) begin
          r = $urandom_range(0, 99);
          key_pool[k] = (r < 10) ? 32'h8000_0000 : (r < 20) ? 32'h7FFF_FFFF : $urandom;
        end
      end
      for (n = 0; n < 62; n++) begin
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 5) begin
          queue_cmd(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
        end else if (ph_kind == PH_FILL) begin
          if (r < 65)      queue_cmd(CMD_APPEND, pick_key(), $urandom, $urandom, $urandom);
          else if (r < 77) queue_cmd(CMD_LOOKUP, pick_key(), $urandom, $urandom, $urandom);
          else if (r < 88) queue_cmd(CMD_EDIT, pick_key(), $urandom, $urandom, pick_key());
          else             queue_cmd(CMD_REMOVE, pick_key(), $urandom, $urandom, $urandom);
        end else begin
          if (r < 15)      queue_cmd(CMD_APPEND, pick_key(), $urandom, $urandom, $urandom);
          else if (r < 35) queue_cmd(CMD_LOOKUP, pick_key(), $urandom, $urandom, $urandom);
          else if (r < 50) queue_cmd(CMD_EDIT, pick_key(), $urandom, $urandom, pick_key());
          else             queue_cmd(CMD_REMOVE, pick_key(), $urandom, $urandom, $urandom);
        end
      end
      if (ph == 14) wait_for_drain();
    end

    while (!(queued_commands.size() == 0 && !in_valid)) @(posedge clk);
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Covered %0d commands and %0d results; table peaked at %0d records.",
             sent_count, result_count, peak_count);
    $display("Status mix: ok %0d, not found %0d, empty %0d, full %0d.",
             status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_EMPTY],
             status_seen[ST_FULL]);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found.", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
